>>> rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants for the software timer table: request and
// event codes, the layout of one stored timer entry and the controller states.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int TIMERS_DEF = 16;
    localparam int RESULT_CAP = 16;
    localparam int ID_W       = 16;
    localparam int DUR_W      = 32;
    localparam int ELAPSED_W  = 16;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        EV_FIRED   = 3'd0,
        EV_ADDED   = 3'd1,
        EV_FULL    = 3'd2,
        EV_REMOVED = 3'd3,
        EV_NOTHING = 3'd4
    } t_event_kind;

    typedef struct packed {
        logic [DUR_W-1:0] period;
        logic [DUR_W-1:0] remaining;
        logic             cyclic;
        logic [ID_W-1:0]  ident;
    } t_entry;

    typedef struct packed {
        t_event_kind     kind;
        logic [ID_W-1:0] id;
        logic            last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_PICK,
        ST_FIND,
        ST_EMIT
    } t_state;

endpackage

>>> rtl/software_timer_table_unit.sv
// Add and remove all go straight to the emit state; remove by id sweeps the entry store until
// the id matches or the sweep ends; a tick sweeps once to count down, then sweeps once more
// per fired event to pick it (at most 16 fired events per tick).
// A new request is taken only in the idle state, the cycle after the last result of the current one
// is loaded; the single read port of the entry RAM, swept once per pass, sets the pace of each pass.
// Reset (synchronous, active low) clears all valid flags and the id counter.
// ----------------------------------------------------------------------------
// software_timer_table_unit
// Table of software timers with add, remove by id, remove all and tick
// requests; expired timers fire in ascending period order.
// ----------------------------------------------------------------------------
module software_timer_table_unit #(
    parameter int TIMERS = stt_pkg::TIMERS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_req_type,
    input  logic [stt_pkg::DUR_W-1:0]     i_duration,
    input  logic                          i_cyclic,
    input  logic [stt_pkg::ID_W-1:0]      i_timer_id,
    input  logic [stt_pkg::ELAPSED_W-1:0] i_elapsed,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_event_kind,
    output logic [stt_pkg::ID_W-1:0]      o_result_id,
    output logic                          o_last
);
    import stt_pkg::*;

    // Address width of the entry store; one bit at least for a single timer.
    localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;

    logic          res_load;
    t_result       res;
    logic          res_free;

    // Output register: the controller may load a new item in the same cycle
    // that the current one is taken downstream.
    logic          r_out_valid;
    t_result       r_out;

    assign res_free = !r_out_valid || !i_stall;

    // The entry RAM keeps period, countdown, mode and id of every timer.
    stt_entry_ram #(
        .TIMERS (TIMERS),
        .AW     (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The controller owns the valid and due flags and sequences every request.
    stt_ctrl #(
        .TIMERS (TIMERS),
        .AW     (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .i_req_type  (i_req_type),
        .i_duration  (i_duration),
        .i_cyclic    (i_cyclic),
        .i_timer_id  (i_timer_id),
        .i_elapsed   (i_elapsed),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_res_load  (res_load),
        .o_res       (res),
        .i_res_free  (res_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_kind = r_out.kind;
    assign o_result_id  = r_out.id;
    assign o_last       = r_out.last;

endmodule

>>> rtl/stt_entry_ram.sv
// ----------------------------------------------------------------------------
// stt_entry_ram
// Single-port-write, single-port-read entry store with registered read data.
// ----------------------------------------------------------------------------
module stt_entry_ram #(
    parameter int TIMERS = 16,
    parameter int AW     = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  stt_pkg::t_entry   i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output stt_pkg::t_entry   o_rdata
);
    import stt_pkg::*;

    t_entry r_mem [TIMERS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl
// Request sequencer: holds the valid and due flags, sweeps the entry store
// for countdown, firing order and id search, and hands results to the output.
// ----------------------------------------------------------------------------
module stt_ctrl #(
    parameter int TIMERS = 16,
    parameter int AW     = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_req_type,
    input  logic [stt_pkg::DUR_W-1:0]         i_duration,
    input  logic                              i_cyclic,
    input  logic [stt_pkg::ID_W-1:0]          i_timer_id,
    input  logic [stt_pkg::ELAPSED_W-1:0]     i_elapsed,
    output logic                              o_mem_we,
    output logic [AW-1:0]                     o_mem_waddr,
    output stt_pkg::t_entry                   o_mem_wdata,
    output logic [AW-1:0]                     o_mem_raddr,
    input  stt_pkg::t_entry                   i_mem_rdata,
    output logic                              o_res_load,
    output stt_pkg::t_result                  o_res,
    input  logic                              i_res_free
);
    import stt_pkg::*;

    localparam int CW = $clog2(TIMERS + 1);
    localparam int FW = $clog2(RESULT_CAP + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(TIMERS - 1);

    t_state                r_state, n_state;
    logic [TIMERS-1:0]     r_valid, n_valid;
    logic [TIMERS-1:0]     r_due, n_due;
    logic [ID_W-1:0]       r_next_ident, n_next_ident;
    logic [ELAPSED_W-1:0]  r_elapsed, n_elapsed;
    logic [ID_W-1:0]       r_tid, n_tid;
    logic [AW-1:0]         r_rd_idx, n_rd_idx;
    logic                  r_rd_more, n_rd_more;
    logic                  r_dv, n_dv;
    logic [AW-1:0]         r_dv_idx, n_dv_idx;
    logic [CW-1:0]         r_left, n_left;
    logic [FW-1:0]         r_budget, n_budget;
    logic                  r_best_found, n_best_found;
    logic [AW-1:0]         r_best_idx, n_best_idx;
    logic [DUR_W-1:0]      r_best_period, n_best_period;
    logic [ID_W-1:0]       r_best_ident, n_best_ident;
    logic                  r_best_cyc, n_best_cyc;
    t_result               r_res, n_res;
    logic                  r_wb, n_wb;
    logic                  r_more, n_more;

    logic                  free_any;
    logic [AW-1:0]         free_idx;
    logic                  sweep_end;
    logic                  accept;
    logic                  ev_last;
    t_entry                ent;

    // Lowest free slot for an add.
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TIMERS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    assign sweep_end = r_dv && (r_dv_idx == LAST_IDX);
    assign accept    = (r_state == ST_IDLE) && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_due        <= '0;
            r_next_ident <= '0;
            r_rd_more    <= 1'b0;
            r_dv         <= 1'b0;
            r_left       <= '0;
            r_budget     <= '0;
            r_best_found <= 1'b0;
            r_wb         <= 1'b0;
            r_more       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_due        <= n_due;
            r_next_ident <= n_next_ident;
            r_rd_more    <= n_rd_more;
            r_dv         <= n_dv;
            r_left       <= n_left;
            r_budget     <= n_budget;
            r_best_found <= n_best_found;
            r_wb         <= n_wb;
            r_more       <= n_more;
        end
        r_elapsed     <= n_elapsed;
        r_tid         <= n_tid;
        r_rd_idx      <= n_rd_idx;
        r_dv_idx      <= n_dv_idx;
        r_best_idx    <= n_best_idx;
        r_best_period <= n_best_period;
        r_best_ident  <= n_best_ident;
        r_best_cyc    <= n_best_cyc;
        r_res         <= n_res;
    end

    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid;
        n_due         = r_due;
        n_next_ident  = r_next_ident;
        n_elapsed     = r_elapsed;
        n_tid         = r_tid;
        n_rd_idx      = r_rd_idx;
        n_rd_more     = r_rd_more;
        n_dv          = r_dv;
        n_dv_idx      = r_dv_idx;
        n_left        = r_left;
        n_budget      = r_budget;
        n_best_found  = r_best_found;
        n_best_idx    = r_best_idx;
        n_best_period = r_best_period;
        n_best_ident  = r_best_ident;
        n_best_cyc    = r_best_cyc;
        n_res         = r_res;
        n_wb          = r_wb;
        n_more        = r_more;
        o_in_stall    = (r_state != ST_IDLE);
        o_mem_we      = 1'b0;
        o_mem_waddr   = r_dv_idx;
        o_mem_wdata   = i_mem_rdata;
        o_mem_raddr   = r_rd_idx;
        o_res_load    = 1'b0;
        ent           = i_mem_rdata;
        ev_last       = (r_left == CW'(1)) || (r_budget == FW'(1));

        // Read issue for the sweeping states.
        if (r_state == ST_DEC || r_state == ST_PICK || r_state == ST_FIND) begin
            n_dv     = r_rd_more;
            n_dv_idx = r_rd_idx;
            if (r_rd_more) begin
                if (r_rd_idx == LAST_IDX) begin
                    n_rd_more = 1'b0;
                end else begin
                    n_rd_idx = r_rd_idx + AW'(1);
                end
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_wb   = 1'b0;
                    n_more = 1'b0;
                    unique case (t_req'(i_req_type))
                        REQ_TICK: begin
                            n_elapsed = i_elapsed;
                            n_rd_idx  = '0;
                            n_rd_more = 1'b1;
                            n_dv      = 1'b0;
                            n_left    = '0;
                            n_due     = '0;
                            n_state   = ST_DEC;
                        end
                        REQ_ADD: begin
                            if (free_any) begin
                                o_mem_we              = 1'b1;
                                o_mem_waddr           = free_idx;
                                o_mem_wdata.period    = i_duration;
                                o_mem_wdata.remaining = i_duration;
                                o_mem_wdata.cyclic    = i_cyclic;
                                o_mem_wdata.ident     = r_next_ident;
                                n_valid[free_idx]     = 1'b1;
                                n_res                 = '{EV_ADDED, r_next_ident, 1'b1};
                                n_next_ident          = r_next_ident + ID_W'(1);
                            end else begin
                                n_res = '{EV_FULL, '0, 1'b1};
                            end
                            n_state = ST_EMIT;
                        end
                        REQ_REMOVE: begin
                            n_tid     = i_timer_id;
                            n_rd_idx  = '0;
                            n_rd_more = 1'b1;
                            n_dv      = 1'b0;
                            n_state   = ST_FIND;
                        end
                        REQ_CLEAR: begin
                            n_res   = '{(|r_valid) ? EV_REMOVED : EV_NOTHING, '0, 1'b1};
                            n_valid = '0;
                            n_state = ST_EMIT;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end

            ST_DEC: begin
                if (r_dv && r_valid[r_dv_idx]) begin
                    o_mem_we = 1'b1;
                    if (ent.remaining <= {{(DUR_W-ELAPSED_W){1'b0}}, r_elapsed}) begin
                        n_due[r_dv_idx]       = 1'b1;
                        n_left                = r_left + CW'(1);
                        o_mem_wdata.remaining = '0;
                    end else begin
                        o_mem_wdata.remaining = ent.remaining
                                              - {{(DUR_W-ELAPSED_W){1'b0}}, r_elapsed};
                    end
                end
                if (sweep_end) begin
                    if (n_left == '0) begin
                        n_res   = '{EV_NOTHING, '0, 1'b1};
                        n_state = ST_EMIT;
                    end else begin
                        n_budget     = FW'(RESULT_CAP);
                        n_best_found = 1'b0;
                        n_rd_idx     = '0;
                        n_rd_more    = 1'b1;
                        n_dv         = 1'b0;
                        n_state      = ST_PICK;
                    end
                end
            end

            ST_PICK: begin
                // Strictly smaller replaces, so equal keys keep the lower slot.
                if (r_dv && r_due[r_dv_idx]) begin
                    if (!r_best_found ||
                        ({ent.period, ent.ident} < {r_best_period, r_best_ident})) begin
                        n_best_found  = 1'b1;
                        n_best_idx    = r_dv_idx;
                        n_best_period = ent.period;
                        n_best_ident  = ent.ident;
                        n_best_cyc    = ent.cyclic;
                    end
                end
                if (sweep_end) begin
                    n_res             = '{EV_FIRED, n_best_ident, ev_last};
                    n_more            = !ev_last;
                    n_wb              = 1'b1;
                    n_due[n_best_idx] = 1'b0;
                    n_left            = r_left - CW'(1);
                    n_budget          = r_budget - FW'(1);
                    n_state           = ST_EMIT;
                end
            end

            ST_FIND: begin
                if (r_dv && r_valid[r_dv_idx] && (ent.ident == r_tid)) begin
                    n_valid[r_dv_idx] = 1'b0;
                    n_res             = '{EV_REMOVED, r_tid, 1'b1};
                    n_state           = ST_EMIT;
                end else if (sweep_end) begin
                    n_res   = '{EV_NOTHING, '0, 1'b1};
                    n_state = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (i_res_free) begin
                    o_res_load = 1'b1;
                    if (r_wb) begin
                        if (r_best_cyc) begin
                            o_mem_we              = 1'b1;
                            o_mem_waddr           = r_best_idx;
                            o_mem_wdata.period    = r_best_period;
                            o_mem_wdata.remaining = r_best_period;
                            o_mem_wdata.cyclic    = 1'b1;
                            o_mem_wdata.ident     = r_best_ident;
                        end else begin
                            n_valid[r_best_idx] = 1'b0;
                        end
                    end
                    n_wb = 1'b0;
                    if (r_more) begin
                        n_best_found = 1'b0;
                        n_rd_idx     = '0;
                        n_rd_more    = 1'b1;
                        n_dv         = 1'b0;
                        n_state      = ST_PICK;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    assign o_res = r_res;

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |-> i_res_free)
        else $error("result loaded while output register is occupied");

    a_add_to_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && o_mem_we) |-> !r_valid[o_mem_waddr])
        else $error("add overwrote a live timer entry");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_req'(i_req_type) == REQ_CLEAR) |=> (r_valid == '0))
        else $error("remove all left a timer valid");

    a_pick_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PICK) |-> (r_left != '0 && r_budget != '0))
        else $error("firing sweep started with nothing left to fire");
`endif

endmodule
